// ----- hdl/tsi_pkg.sv -----
package tsi_pkg;

	// Fixed widths of the fields on the stream ports.
	localparam int TGT_W       = 24;
	localparam int SRV_W       = 12;
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 72;
	localparam int IN_PAD_W    = 6;
	localparam int OUT_PAD_W   = 5;

	// Configuration port.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_ADDR_W-1:0] REG_LEFT_REVERSE    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_RIGHT_REVERSE   = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_PEN_DRAW_WIDTH  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_PEN_LIFT_WIDTH  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_SERVO_MIN_WIDTH = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_SERVO_MAX_WIDTH = 3'd5;

	// Reset values of the servo widths.
	localparam int PEN_DRAW_RST  = 1000;
	localparam int PEN_LIFT_RST  = 2000;
	localparam int SERVO_MIN_RST = 500;
	localparam int SERVO_MAX_RST = 2500;
	localparam int SERVO_MID_RST = 1500;

	// Item kinds carried in the input tuser.
	localparam logic KIND_MOVE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Bit positions of the result fields in the output tdata.
	localparam int O_STEP_L    = 0;
	localparam int O_STEP_R    = 1;
	localparam int O_DIR_L     = 2;
	localparam int O_DIR_R     = 3;
	localparam int O_SERVO_LSB = 4;
	localparam int O_FAULT     = 16;
	localparam int O_BUSY      = 17;
	localparam int O_REJ       = 18;
	localparam int O_CNT_L_LSB = 19;
	localparam int O_CNT_R_LSB = 43;

	// Command queue between the front and the back.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	// A decoded input item as it waits in the queue.
	typedef struct packed {
		logic             is_tick;
		logic [TGT_W-1:0] target_left;
		logic [TGT_W-1:0] target_right;
		logic             relative;
		logic             draw;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic             step_left;
		logic             step_right;
		logic             dir_left_pin;
		logic             dir_right_pin;
		logic [SRV_W-1:0] servo_width;
		logic             servo_fault;
		logic             busy_res;
		logic             move_done;
		logic             rejected;
		logic [TGT_W-1:0] count_left;
		logic [TGT_W-1:0] count_right;
	} res_t;

endpackage

// ----- hdl/tsi_front.sv -----
module tsi_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	// target_left[23:0], target_right[47:24], relative[48], draw[49], zeros above
	input  logic [tsi_pkg::IN_TDATA_W-1:0]         in_data,
	// kind[0]
	input  logic                                  in_user,
	output logic                                  push_valid,
	input  logic                                  push_ready,
	output tsi_pkg::cmd_t                         push_cmd
);

	logic          valid_s1;
	logic          live_q;
	tsi_pkg::cmd_t cmd_s1;

	// The stage takes a new transfer when empty or when its item leaves, and only once
	// the block has left reset.
	assign in_ready   = live_q && (!valid_s1 || push_ready);
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			live_q   <= 1'b0;
		end else begin
			live_q <= 1'b1;
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	// Decode the transfer and classify it as a move command or a tick.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1.is_tick      <= (in_user == tsi_pkg::KIND_TICK);
			cmd_s1.target_left  <= in_data[tsi_pkg::TGT_W-1:0];
			cmd_s1.target_right <= in_data[2*tsi_pkg::TGT_W-1:tsi_pkg::TGT_W];
			cmd_s1.relative     <= in_data[2*tsi_pkg::TGT_W];
			cmd_s1.draw         <= in_data[2*tsi_pkg::TGT_W+1];
		end
	end

endmodule

// ----- hdl/tsi_fifo.sv -----
module tsi_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  tsi_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop_ready,
	output tsi_pkg::cmd_t pop_cmd
);

	tsi_pkg::cmd_t                 entry_q [tsi_pkg::Q_DEPTH];
	logic [tsi_pkg::Q_PTR_W-1:0]  wr_ptr_q;
	logic [tsi_pkg::Q_PTR_W-1:0]  rd_ptr_q;
	logic [tsi_pkg::Q_CNT_W-1:0]  count_q;
	logic                          push;
	logic                          pop;

	assign push_ready = (count_q != tsi_pkg::Q_CNT_W'(tsi_pkg::Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + tsi_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + tsi_pkg::Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + tsi_pkg::Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - tsi_pkg::Q_CNT_W'(1);
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ----- hdl/tsi_back.sv -----
module tsi_back #(
	parameter int POS_BITS   = 24,
	parameter int SERVO_BITS = 12
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tsi_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [tsi_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             pop_valid,
	output logic                             pop_ready,
	input  tsi_pkg::cmd_t                    cmd,
	output logic                             res_valid,
	input  logic                             res_ready,
	output tsi_pkg::res_t                    res
);

	localparam int EXT_W = (POS_BITS > tsi_pkg::TGT_W) ? POS_BITS : tsi_pkg::TGT_W;
	localparam logic [SERVO_BITS-1:0] DRAW_RST  = SERVO_BITS'(tsi_pkg::PEN_DRAW_RST);
	localparam logic [SERVO_BITS-1:0] LIFT_RST  = SERVO_BITS'(tsi_pkg::PEN_LIFT_RST);
	localparam logic [SERVO_BITS-1:0] MIN_RST   = SERVO_BITS'(tsi_pkg::SERVO_MIN_RST);
	localparam logic [SERVO_BITS-1:0] MAX_RST   = SERVO_BITS'(tsi_pkg::SERVO_MAX_RST);
	localparam logic [SERVO_BITS-1:0] MID_RST   = SERVO_BITS'(tsi_pkg::SERVO_MID_RST);
	localparam logic [POS_BITS-1:0]   POS_MIN   = {1'b1, {(POS_BITS-1){1'b0}}};
	localparam logic [POS_BITS-1:0]   POS_ONE   = POS_BITS'(1);

	// Configuration registers.
	logic                  left_rev_q, right_rev_q;
	logic [SERVO_BITS-1:0] draw_w_q, lift_w_q, min_w_q, max_w_q;

	// Motion state.
	logic [POS_BITS-1:0]   logical_l_q, logical_r_q, counted_l_q, counted_r_q;
	logic [POS_BITS-1:0]   rem_l_q, rem_r_q, major_q, minor_q;
	logic signed [POS_BITS:0] accum_q;
	logic                  minor_is_left_q, sign_l_q, sign_r_q, moving_q;
	logic [SERVO_BITS-1:0] servo_cur_q;

	// Next-state values.
	logic [POS_BITS-1:0]   logical_l_nxt, logical_r_nxt, counted_l_nxt, counted_r_nxt;
	logic [POS_BITS-1:0]   rem_l_nxt, rem_r_nxt, major_nxt, minor_nxt;
	logic signed [POS_BITS:0] accum_nxt;
	logic                  minor_is_left_nxt, sign_l_nxt, sign_r_nxt, moving_nxt;
	logic [SERVO_BITS-1:0] servo_cur_nxt;

	// Move command arithmetic.
	logic signed [EXT_W-1:0] tl_ext, tr_ext;
	logic [POS_BITS-1:0]   tgt_l, tgt_r, dist_l, dist_r, mag_l, mag_r;
	logic                  neg_l, neg_r;
	logic [SERVO_BITS-1:0] want, sw;
	logic                  fault;

	// Tick arithmetic.
	logic signed [POS_BITS:0] acc_add, acc_sub;
	logic                  sminor, sl, sr, done, rej, pins;

	logic                  fire;
	logic                  out_valid_q;
	tsi_pkg::res_t         res_q;
	tsi_pkg::res_t         res_nxt;

	assign pop_ready = !out_valid_q || res_ready;
	assign fire      = pop_valid && pop_ready;
	assign res_valid = out_valid_q;
	assign res       = res_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_rev_q  <= 1'b0;
			right_rev_q <= 1'b0;
			draw_w_q    <= DRAW_RST;
			lift_w_q    <= LIFT_RST;
			min_w_q     <= MIN_RST;
			max_w_q     <= MAX_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				tsi_pkg::REG_LEFT_REVERSE:    left_rev_q  <= cfg_wdata[0];
				tsi_pkg::REG_RIGHT_REVERSE:   right_rev_q <= cfg_wdata[0];
				tsi_pkg::REG_PEN_DRAW_WIDTH:  draw_w_q    <= SERVO_BITS'(cfg_wdata);
				tsi_pkg::REG_PEN_LIFT_WIDTH:  lift_w_q    <= SERVO_BITS'(cfg_wdata);
				tsi_pkg::REG_SERVO_MIN_WIDTH: min_w_q     <= SERVO_BITS'(cfg_wdata);
				tsi_pkg::REG_SERVO_MAX_WIDTH: max_w_q     <= SERVO_BITS'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// Axis distances of a move. A relative offset is the distance itself.
	// Reversal negates the distance, which leaves its magnitude unchanged.
	always_comb begin
		tl_ext = EXT_W'($signed(cmd.target_left));
		tr_ext = EXT_W'($signed(cmd.target_right));
		tgt_l  = tl_ext[POS_BITS-1:0];
		tgt_r  = tr_ext[POS_BITS-1:0];
		dist_l = cmd.relative ? tgt_l : (tgt_l - logical_l_q);
		dist_r = cmd.relative ? tgt_r : (tgt_r - logical_r_q);
		mag_l  = dist_l[POS_BITS-1] ? ({POS_BITS{1'b0}} - dist_l) : dist_l;
		mag_r  = dist_r[POS_BITS-1] ? ({POS_BITS{1'b0}} - dist_r) : dist_r;
		neg_l  = left_rev_q ?
			((dist_l != '0) && (!dist_l[POS_BITS-1] || (dist_l == POS_MIN))) :
			dist_l[POS_BITS-1];
		neg_r  = right_rev_q ?
			((dist_r != '0) && (!dist_r[POS_BITS-1] || (dist_r == POS_MIN))) :
			dist_r[POS_BITS-1];
		want   = cmd.draw ? draw_w_q : lift_w_q;
	end

	// Error accumulator of the minor axis.
	always_comb begin
		acc_add = accum_q + $signed({1'b0, minor_q});
		acc_sub = acc_add - $signed({1'b0, major_q});
		sminor  = !acc_add[POS_BITS] && (acc_add != '0);
	end

	// Execution of the item at the head of the queue.
	always_comb begin
		logical_l_nxt     = logical_l_q;
		logical_r_nxt     = logical_r_q;
		counted_l_nxt     = counted_l_q;
		counted_r_nxt     = counted_r_q;
		rem_l_nxt         = rem_l_q;
		rem_r_nxt         = rem_r_q;
		major_nxt         = major_q;
		minor_nxt         = minor_q;
		accum_nxt         = accum_q;
		minor_is_left_nxt = minor_is_left_q;
		sign_l_nxt        = sign_l_q;
		sign_r_nxt        = sign_r_q;
		moving_nxt        = moving_q;
		servo_cur_nxt     = servo_cur_q;
		sw                = '0;
		fault             = 1'b0;
		sl                = 1'b0;
		sr                = 1'b0;
		done              = 1'b0;
		rej               = 1'b0;

		if (!cmd.is_tick) begin
			if (moving_q) begin
				rej = 1'b1;
			end else begin
				// Pen servo request.
				if (want != servo_cur_q) begin
					if ((want >= min_w_q) && (want <= max_w_q)) begin
						servo_cur_nxt = want;
						sw            = want;
					end else begin
						fault = 1'b1;
					end
				end
				logical_l_nxt = cmd.relative ? (tgt_l + logical_l_q) : tgt_l;
				logical_r_nxt = cmd.relative ? (tgt_r + logical_r_q) : tgt_r;
				// A move with any distance starts motion.
				if ((mag_l != '0) || (mag_r != '0)) begin
					sign_l_nxt        = neg_l;
					sign_r_nxt        = neg_r;
					rem_l_nxt         = mag_l;
					rem_r_nxt         = mag_r;
					minor_is_left_nxt = !(mag_l > mag_r);
					major_nxt         = (mag_l > mag_r) ? mag_l : mag_r;
					minor_nxt         = (mag_l > mag_r) ? mag_r : mag_l;
					accum_nxt         = '0;
					moving_nxt        = 1'b1;
				end
			end
		end else if (moving_q) begin
			accum_nxt = sminor ? acc_sub : acc_add;
			if (minor_is_left_q) begin
				sl = sminor && (rem_l_q != '0);
				sr = (rem_r_q != '0);
			end else begin
				sr = sminor && (rem_r_q != '0);
				sl = (rem_l_q != '0);
			end
			if (sl) begin
				rem_l_nxt     = rem_l_q - POS_ONE;
				counted_l_nxt = sign_l_q ? (counted_l_q + POS_ONE) : (counted_l_q - POS_ONE);
			end
			if (sr) begin
				rem_r_nxt     = rem_r_q - POS_ONE;
				counted_r_nxt = sign_r_q ? (counted_r_q + POS_ONE) : (counted_r_q - POS_ONE);
			end
			if ((rem_l_nxt == '0) && (rem_r_nxt == '0)) begin
				moving_nxt = 1'b0;
				done       = 1'b1;
			end
		end

		// Result fields show the state after the item.
		pins                  = moving_nxt || done;
		res_nxt.step_left     = sl;
		res_nxt.step_right    = sr;
		res_nxt.dir_left_pin  = pins && !sign_l_nxt;
		res_nxt.dir_right_pin = pins && !sign_r_nxt;
		res_nxt.servo_width   = tsi_pkg::SRV_W'(sw);
		res_nxt.servo_fault   = fault;
		res_nxt.busy_res      = moving_nxt;
		res_nxt.move_done     = done;
		res_nxt.rejected      = rej;
		res_nxt.count_left    = tsi_pkg::TGT_W'(counted_l_nxt);
		res_nxt.count_right   = tsi_pkg::TGT_W'(counted_r_nxt);
	end

	// State update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			logical_l_q     <= '0;
			logical_r_q     <= '0;
			counted_l_q     <= '0;
			counted_r_q     <= '0;
			rem_l_q         <= '0;
			rem_r_q         <= '0;
			major_q         <= '0;
			minor_q         <= '0;
			accum_q         <= '0;
			minor_is_left_q <= 1'b0;
			sign_l_q        <= 1'b0;
			sign_r_q        <= 1'b0;
			moving_q        <= 1'b0;
			servo_cur_q     <= MID_RST;
		end else if (fire) begin
			logical_l_q     <= logical_l_nxt;
			logical_r_q     <= logical_r_nxt;
			counted_l_q     <= counted_l_nxt;
			counted_r_q     <= counted_r_nxt;
			rem_l_q         <= rem_l_nxt;
			rem_r_q         <= rem_r_nxt;
			major_q         <= major_nxt;
			minor_q         <= minor_nxt;
			accum_q         <= accum_nxt;
			minor_is_left_q <= minor_is_left_nxt;
			sign_l_q        <= sign_l_nxt;
			sign_r_q        <= sign_r_nxt;
			moving_q        <= moving_nxt;
			servo_cur_q     <= servo_cur_nxt;
		end
	end

	// Output register: holds a result until the transfer completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_nxt;
		end
	end

endmodule

// ----- hdl/two_axis_step_interpolator_top.sv -----
// Path: a result passes the input register, then the command queue, then the
// execution unit's output register; a stall on either side can hold it on the way.
// Throughput: one item per cycle unless the output stalls, set by the execution unit.
// A four-entry queue lets the input side keep taking items while the output is stalled.
// Reset: arst_n clears control, positions and motion state asynchronously, loads the
// register reset values and the middle servo width; no item is taken while it is low,
// and the input side opens once a live flag has been registered after it rises.
module two_axis_step_interpolator_top #(
	parameter int POS_BITS   = 24,
	parameter int SERVO_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// target_left[23:0], target_right[47:24], relative[48], draw[49], zeros [55:50]
	input  logic [tsi_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	// kind[0]
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// step_left[0], step_right[1], dir_left_pin[2], dir_right_pin[3], servo_width[15:4],
	// servo_fault[16], busy_res[17], rejected[18], count_left[42:19],
	// count_right[66:43], zeros [71:67]
	output logic [tsi_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	// move_done
	output logic                                m_axis_tlast,
	input  logic                                cfg_we,
	input  logic [tsi_pkg::CFG_ADDR_W-1:0]       cfg_addr,
	input  logic [tsi_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	logic          push_valid, push_ready, pop_valid, pop_ready;
	tsi_pkg::cmd_t push_cmd, pop_cmd;
	tsi_pkg::res_t res;

	tsi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_data    (s_axis_tdata),
		.in_user    (s_axis_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	tsi_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	tsi_back #(
		.POS_BITS   (POS_BITS),
		.SERVO_BITS (SERVO_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.cmd       (pop_cmd),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	// Pack the result fields from the lowest bit up.
	assign m_axis_tdata = {
		{tsi_pkg::OUT_PAD_W{1'b0}},
		res.count_right,
		res.count_left,
		res.rejected,
		res.busy_res,
		res.servo_fault,
		res.servo_width,
		res.dir_right_pin,
		res.dir_left_pin,
		res.step_right,
		res.step_left
	};
	assign m_axis_tlast = res.move_done;

endmodule

// ----- hdl/tsi_checker.sv -----
module tsi_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [tsi_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic                             m_axis_tlast
);

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output result changed while stalled");

	// The last step slot of a move ends the busy state.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[tsi_pkg::O_BUSY])
		else $error("move done reported while still busy");

	// A command is only rejected during a move.
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[tsi_pkg::O_REJ] |-> m_axis_tdata[tsi_pkg::O_BUSY])
		else $error("command rejected while idle");

	// A rejected command moves nothing.
	a_rej_still: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[tsi_pkg::O_REJ] |->
			!m_axis_tdata[tsi_pkg::O_STEP_L] && !m_axis_tdata[tsi_pkg::O_STEP_R] &&
			!m_axis_tlast)
		else $error("rejected command produced motion");

	// Direction pins are low outside a move.
	a_pins_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[tsi_pkg::O_BUSY] && !m_axis_tlast |->
			!m_axis_tdata[tsi_pkg::O_DIR_L] && !m_axis_tdata[tsi_pkg::O_DIR_R])
		else $error("direction pin raised while idle");

endmodule

bind two_axis_step_interpolator_top tsi_checker u_tsi_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ----- sim/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_REGS     = tsi_pkg::REG_SERVO_MAX_WIDTH + 1;
	localparam int ITEMS_TARGET = 1700;
	localparam int PHASE_ITEMS  = 220;

	// Predicts the slot results of the interpolator and checks them in order.
	class interp_scoreboard;
		// Copies of the configuration registers.
		bit                        left_rev, right_rev;
		logic [tsi_pkg::SRV_W-1:0] draw_w, lift_w, min_w, max_w;
		// Motion state.
		logic [tsi_pkg::TGT_W-1:0] logical_l, logical_r, counted_l, counted_r;
		int unsigned               remain_l, remain_r, major_steps, minor_steps;
		longint                    accum;
		bit                        minor_left, back_l, back_r, moving;
		logic [tsi_pkg::SRV_W-1:0] servo_now;
		// Expected slot results, oldest first.
		tsi_pkg::res_t             expected_slots[$];
		int                        mismatches, strays, results_seen;
		int                        n_moves, n_refused, n_ticks, n_done, n_servo, n_faults;

		function new();
			left_rev = 0;
			right_rev = 0;
			draw_w = tsi_pkg::SRV_W'(tsi_pkg::PEN_DRAW_RST);
			lift_w = tsi_pkg::SRV_W'(tsi_pkg::PEN_LIFT_RST);
			min_w = tsi_pkg::SRV_W'(tsi_pkg::SERVO_MIN_RST);
			max_w = tsi_pkg::SRV_W'(tsi_pkg::SERVO_MAX_RST);
			logical_l = '0;
			logical_r = '0;
			counted_l = '0;
			counted_r = '0;
			remain_l = 0;
			remain_r = 0;
			major_steps = 0;
			minor_steps = 0;
			accum = 0;
			minor_left = 0;
			back_l = 0;
			back_r = 0;
			moving = 0;
			servo_now = tsi_pkg::SRV_W'(tsi_pkg::SERVO_MID_RST);
		endfunction

		function void write_reg(logic [tsi_pkg::CFG_ADDR_W-1:0] addr,
				logic [tsi_pkg::CFG_DATA_W-1:0] data);
			case (addr)
				tsi_pkg::REG_LEFT_REVERSE: left_rev = data[0];
				tsi_pkg::REG_RIGHT_REVERSE: right_rev = data[0];
				tsi_pkg::REG_PEN_DRAW_WIDTH: draw_w = data;
				tsi_pkg::REG_PEN_LIFT_WIDTH: lift_w = data;
				tsi_pkg::REG_SERVO_MIN_WIDTH: min_w = data;
				tsi_pkg::REG_SERVO_MAX_WIDTH: max_w = data;
				default: ;
			endcase
		endfunction

		// Result of one slot given the motion state after the item.
		function tsi_pkg::res_t slot_outcome(bit sl, bit sr, logic [tsi_pkg::SRV_W-1:0] sw,
				bit fault, bit done, bit rej);
			tsi_pkg::res_t r;
			bit            pins;
			pins = moving || done;
			r.step_left = sl;
			r.step_right = sr;
			r.dir_left_pin = pins && !back_l;
			r.dir_right_pin = pins && !back_r;
			r.servo_width = sw;
			r.servo_fault = fault;
			r.busy_res = moving;
			r.move_done = done;
			r.rejected = rej;
			r.count_left = counted_l;
			r.count_right = counted_r;
			return r;
		endfunction

		// Advances the interpolator by one accepted input item.
		function void note_item(bit is_tick, logic [tsi_pkg::TGT_W-1:0] tgt_l,
				logic [tsi_pkg::TGT_W-1:0] tgt_r, bit rel, bit draw);
			logic [tsi_pkg::SRV_W-1:0]        want_w, new_w;
			logic [tsi_pkg::TGT_W-1:0]        dest_l, dest_r;
			logic signed [tsi_pkg::TGT_W-1:0] dist_l, dist_r;
			int unsigned                      mag_l, mag_r;
			bit                               fault, pulse_minor, sl, sr, done;
			new_w = '0;
			fault = 0;
			pulse_minor = 0;
			sl = 0;
			sr = 0;
			done = 0;
			if (!is_tick) begin
				// A command during a move is refused and changes nothing.
				if (moving) begin
					n_refused++;
					expected_slots.push_back(slot_outcome(0, 0, '0, 0, 0, 1));
					return;
				end
				n_moves++;
				want_w = draw ? draw_w : lift_w;
				if (want_w != servo_now) begin
					if (want_w >= min_w && want_w <= max_w) begin
						servo_now = want_w;
						new_w = want_w;
						n_servo++;
					end else begin
						fault = 1;
						n_faults++;
					end
				end
				dest_l = rel ? tgt_l + logical_l : tgt_l;
				dest_r = rel ? tgt_r + logical_r : tgt_r;
				dist_l = dest_l - logical_l;
				dist_r = dest_r - logical_r;
				if (left_rev)
					dist_l = -dist_l;
				if (right_rev)
					dist_r = -dist_r;
				logical_l = dest_l;
				logical_r = dest_r;
				mag_l = (dist_l < 0) ? -int'(dist_l) : int'(dist_l);
				mag_r = (dist_r < 0) ? -int'(dist_r) : int'(dist_r);
				// Only a move with some distance latches a new direction.
				if (mag_l != 0 || mag_r != 0) begin
					back_l = dist_l < 0;
					back_r = dist_r < 0;
					remain_l = mag_l;
					remain_r = mag_r;
					minor_left = !(mag_l > mag_r);
					major_steps = minor_left ? mag_r : mag_l;
					minor_steps = minor_left ? mag_l : mag_r;
					accum = 0;
					moving = 1;
				end
				expected_slots.push_back(slot_outcome(0, 0, new_w, fault, 0, 0));
			end else begin
				n_ticks++;
				if (!moving) begin
					expected_slots.push_back(slot_outcome(0, 0, '0, 0, 0, 0));
					return;
				end
				// Error accumulator decides whether the minor axis steps.
				accum = accum + longint'(minor_steps);
				if (accum > 0) begin
					pulse_minor = 1;
					accum = accum - longint'(major_steps);
				end
				if (minor_left) begin
					sl = pulse_minor && remain_l > 0;
					sr = remain_r > 0;
				end else begin
					sr = pulse_minor && remain_r > 0;
					sl = remain_l > 0;
				end
				if (sl) begin
					remain_l--;
					counted_l = back_l ? counted_l + 1'b1 : counted_l - 1'b1;
				end
				if (sr) begin
					remain_r--;
					counted_r = back_r ? counted_r + 1'b1 : counted_r - 1'b1;
				end
				if (remain_l == 0 && remain_r == 0) begin
					moving = 0;
					done = 1;
					n_done++;
				end
				expected_slots.push_back(slot_outcome(sl, sr, '0, 0, done, 0));
			end
		endfunction

		function bit field_differs(string name, logic [31:0] want, logic [31:0] got);
			if (want === got)
				return 0;
			if (mismatches < 10)
				$display("%0t: result %0d field %s expected 0x%0h, got 0x%0h", $realtime,
					results_seen, name, want, got);
			return 1;
		endfunction

		// Compares one result transfer with the oldest expectation.
		function void check_result(logic [tsi_pkg::OUT_TDATA_W-1:0] data, logic last);
			tsi_pkg::res_t want, got;
			bit            bad;
			results_seen++;
			if (expected_slots.size() == 0) begin
				strays++;
				if (strays <= 10)
					$display("%0t: result %0d arrived with nothing expected", $realtime,
						results_seen);
				return;
			end
			want = expected_slots.pop_front();
			got.step_left = data[tsi_pkg::O_STEP_L];
			got.step_right = data[tsi_pkg::O_STEP_R];
			got.dir_left_pin = data[tsi_pkg::O_DIR_L];
			got.dir_right_pin = data[tsi_pkg::O_DIR_R];
			got.servo_width = data[tsi_pkg::O_SERVO_LSB +: tsi_pkg::SRV_W];
			got.servo_fault = data[tsi_pkg::O_FAULT];
			got.busy_res = data[tsi_pkg::O_BUSY];
			got.move_done = last;
			got.rejected = data[tsi_pkg::O_REJ];
			got.count_left = data[tsi_pkg::O_CNT_L_LSB +: tsi_pkg::TGT_W];
			got.count_right = data[tsi_pkg::O_CNT_R_LSB +: tsi_pkg::TGT_W];
			bad = 0;
			bad |= field_differs("step_left", 32'(want.step_left), 32'(got.step_left));
			bad |= field_differs("step_right", 32'(want.step_right), 32'(got.step_right));
			bad |= field_differs("dir_left_pin", 32'(want.dir_left_pin), 32'(got.dir_left_pin));
			bad |= field_differs("dir_right_pin", 32'(want.dir_right_pin),
				32'(got.dir_right_pin));
			bad |= field_differs("servo_width", 32'(want.servo_width), 32'(got.servo_width));
			bad |= field_differs("servo_fault", 32'(want.servo_fault), 32'(got.servo_fault));
			bad |= field_differs("busy_res", 32'(want.busy_res), 32'(got.busy_res));
			bad |= field_differs("move_done", 32'(want.move_done), 32'(got.move_done));
			bad |= field_differs("rejected", 32'(want.rejected), 32'(got.rejected));
			bad |= field_differs("count_left", 32'(want.count_left), 32'(got.count_left));
			bad |= field_differs("count_right", 32'(want.count_right), 32'(got.count_right));
			if (bad)
				mismatches++;
		endfunction
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [tsi_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                            s_axis_tuser = 1'b0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [tsi_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                            m_axis_tlast;
	logic                            cfg_we = 1'b0;
	logic [tsi_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
	logic [tsi_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

	interp_scoreboard sb = new();

	int items_sent = 0;
	int settings_applied = 0;
	int send_run = 0;
	int hold_cnt = 0;
	int ready_run = 0;
	int ready_pick;

	two_axis_step_interpolator_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Output side: random stalls, mostly short, with the odd long one and open stretches.
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			m_axis_tready <= 1'b0;
			hold_cnt--;
		end else begin
			m_axis_tready <= 1'b1;
			if (ready_run != 0) begin
				ready_run--;
			end else begin
				ready_pick = $urandom_range(0, 99);
				if (ready_pick < 4)
					ready_run = $urandom_range(40, 150);
				else if (ready_pick < 30)
					hold_cnt = $urandom_range(1, 3);
				else if (ready_pick < 36)
					hold_cnt = $urandom_range(4, 12);
				else if (ready_pick < 38)
					hold_cnt = $urandom_range(20, 60);
			end
		end
	end

	// Every result transfer is checked against the prediction.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tlast);
	end

	// Offers one item after a random gap and notes it once the transfer happens.
	task automatic send_item(input logic kind, input logic [tsi_pkg::TGT_W-1:0] tgt_l,
			input logic [tsi_pkg::TGT_W-1:0] tgt_r, input logic rel, input logic draw);
		int gap;
		int pick;
		if (send_run > 0) begin
			gap = 0;
			send_run--;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				send_run = $urandom_range(30, 120);
				gap = 0;
			end else if (pick < 60) begin
				gap = 0;
			end else if (pick < 88) begin
				gap = $urandom_range(1, 3);
			end else if (pick < 98) begin
				gap = $urandom_range(4, 10);
			end else begin
				gap = $urandom_range(20, 50);
			end
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= {{tsi_pkg::IN_PAD_W{1'b0}}, draw, rel, tgt_r, tgt_l};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_item(kind == tsi_pkg::KIND_TICK, tgt_l, tgt_r, rel, draw);
		items_sent++;
	endtask

	// A step slot; its target fields carry random data that must be ignored.
	task automatic send_tick();
		send_item(tsi_pkg::KIND_TICK, tsi_pkg::TGT_W'($urandom), tsi_pkg::TGT_W'($urandom),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// A move by the given offsets, sent either as relative or as an absolute target.
	task automatic start_move(input logic rel, input int off_l, input int off_r,
			input logic draw);
		if (rel)
			send_item(tsi_pkg::KIND_MOVE, tsi_pkg::TGT_W'(off_l), tsi_pkg::TGT_W'(off_r), 1'b1,
				draw);
		else
			send_item(tsi_pkg::KIND_MOVE, sb.logical_l + tsi_pkg::TGT_W'(off_l),
				sb.logical_r + tsi_pkg::TGT_W'(off_r), 1'b0, draw);
	endtask

	// Ticks until the move finishes, slipping in commands that must be refused.
	task automatic finish_motion();
		while (sb.moving) begin
			if ($urandom_range(0, 99) < 6)
				send_item(tsi_pkg::KIND_MOVE, tsi_pkg::TGT_W'($urandom),
					tsi_pkg::TGT_W'($urandom), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			else
				send_tick();
		end
	endtask

	// Holds the input side until every expected result has been taken.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_slots.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes all six registers once the block has gone idle.
	task automatic apply_config(input logic [tsi_pkg::CFG_DATA_W-1:0] lr,
			input logic [tsi_pkg::CFG_DATA_W-1:0] rr,
			input logic [tsi_pkg::CFG_DATA_W-1:0] dw,
			input logic [tsi_pkg::CFG_DATA_W-1:0] lw,
			input logic [tsi_pkg::CFG_DATA_W-1:0] mn,
			input logic [tsi_pkg::CFG_DATA_W-1:0] mx);
		logic [tsi_pkg::CFG_DATA_W-1:0] vals [NUM_REGS];
		vals[tsi_pkg::REG_LEFT_REVERSE] = lr;
		vals[tsi_pkg::REG_RIGHT_REVERSE] = rr;
		vals[tsi_pkg::REG_PEN_DRAW_WIDTH] = dw;
		vals[tsi_pkg::REG_PEN_LIFT_WIDTH] = lw;
		vals[tsi_pkg::REG_SERVO_MIN_WIDTH] = mn;
		vals[tsi_pkg::REG_SERVO_MAX_WIDTH] = mx;
		wait_drained();
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= tsi_pkg::CFG_ADDR_W'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
			sb.write_reg(tsi_pkg::CFG_ADDR_W'(i), vals[i]);
		end
		cfg_we <= 1'b0;
		settings_applied++;
	endtask

	// Pen width for a random setting: mostly inside the window, sometimes on an edge or outside.
	function automatic logic [tsi_pkg::CFG_DATA_W-1:0] pen_width(
			logic [tsi_pkg::CFG_DATA_W-1:0] lo, logic [tsi_pkg::CFG_DATA_W-1:0] hi);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 2)
			return tsi_pkg::CFG_DATA_W'($urandom_range(0, 4095));
		if (pick == 2)
			return lo;
		if (pick == 3)
			return hi;
		return tsi_pkg::CFG_DATA_W'($urandom_range(lo, hi));
	endfunction

	task automatic random_config();
		logic [tsi_pkg::CFG_DATA_W-1:0] lo, hi;
		if ($urandom_range(0, 6) == 0) begin
			// Widest window with widths at the very ends.
			lo = '0;
			hi = '1;
			apply_config(tsi_pkg::CFG_DATA_W'($urandom_range(0, 1)),
				tsi_pkg::CFG_DATA_W'($urandom_range(0, 1)),
				$urandom_range(0, 1) ? '1 : '0, $urandom_range(0, 1) ? '1 : '0, lo, hi);
		end else begin
			lo = tsi_pkg::CFG_DATA_W'($urandom_range(0, 2000));
			hi = tsi_pkg::CFG_DATA_W'($urandom_range(lo, 4095));
			apply_config(tsi_pkg::CFG_DATA_W'($urandom_range(0, 1)),
				tsi_pkg::CFG_DATA_W'($urandom_range(0, 1)),
				pen_width(lo, hi), pen_width(lo, hi), lo, hi);
		end
	endtask

	// Step distance of one axis: mostly short, a few longer, some zero.
	function automatic int step_offset();
		int pick;
		int span;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			span = 0;
		else if (pick < 85)
			span = $urandom_range(1, 16);
		else if (pick < 97)
			span = $urandom_range(17, 64);
		else
			span = $urandom_range(65, 200);
		return $urandom_range(0, 1) ? span : -span;
	endfunction

	// One random stretch: a complete move with its slots, or a few idle slots as noise.
	task automatic run_sequence();
		int off_l, off_r;
		if ($urandom_range(0, 99) < 8) begin
			repeat ($urandom_range(1, 3)) send_tick();
		end else begin
			off_l = step_offset();
			if ($urandom_range(0, 9) == 0)
				off_r = $urandom_range(0, 1) ? off_l : -off_l;
			else
				off_r = step_offset();
			start_move(1'($urandom_range(0, 1)), off_l, off_r, 1'($urandom_range(0, 1)));
			finish_motion();
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 2)) send_tick();
		end
		if ($urandom_range(0, 49) == 0)
			wait_drained();
	endtask

	initial begin
		int phase_start;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: idle slot, zero move that lifts the pen, then a short drawn move
		// with a refused command carrying extreme targets.
		send_tick();
		start_move(1'b0, 0, 0, 1'b0);
		start_move(1'b1, 3, -5, 1'b1);
		send_item(tsi_pkg::KIND_MOVE, 24'h7FFFFF, 24'h800000, 1'b1, 1'b1);
		finish_motion();
		start_move(1'b0, 0, 0, 1'b1);
		send_tick();

		// Both pen widths outside the window, left axis reversed.
		apply_config(1, 0, 4095, 0, 500, 2500);
		start_move(1'b1, 3, 1, 1'b1);
		finish_motion();
		start_move(1'b1, -1, -3, 1'b0);
		finish_motion();

		// Window at its extremes: widths of zero and full scale are taken.
		apply_config(0, 1, 0, 4095, 0, 4095);
		start_move(1'b1, 4, 4, 1'b1);
		finish_motion();
		start_move(1'b0, -2, 2, 1'b0);
		finish_motion();

		// Empty window, both axes reversed.
		apply_config(1, 1, 800, 900, 900, 800);
		start_move(1'b1, 1, -1, 1'b1);
		finish_motion();

		// Random phases, each under a fresh setting.
		while (items_sent < ITEMS_TARGET) begin
			random_config();
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEMS_TARGET)
				run_sequence();
		end

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Covered %0d items over %0d register settings: %0d moves taken, %0d refused.",
			items_sent, settings_applied, sb.n_moves, sb.n_refused);
		$display("%0d step slots, %0d moves finished, %0d servo changes, %0d width faults.",
			sb.n_ticks, sb.n_done, sb.n_servo, sb.n_faults);
		if (sb.mismatches == 0 && sb.strays == 0 && sb.expected_slots.size() == 0) begin
			$display("two_axis_step_interpolator_top verification clean");
		end else begin
			$display("%0d wrong results, %0d unexpected, %0d missing", sb.mismatches, sb.strays,
				sb.expected_slots.size());
			$display("two_axis_step_interpolator_top verification failed");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(10_000_000);
		$display("Timed out with %0d results outstanding", sb.expected_slots.size());
		$display("two_axis_step_interpolator_top verification failed");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/tsi_pkg.sv
hdl/tsi_front.sv
hdl/tsi_fifo.sv
hdl/tsi_back.sv
hdl/two_axis_step_interpolator_top.sv
hdl/tsi_checker.sv
sim/testbench.sv
